// ===== rtl/core/pst_pkg.sv =====
// Package for the priority task scheduler: action and status codes, the
// controller state type and the structs passed between the top level and the cells.
// No dependencies.
package pst_pkg;

   // Width of a task identifier; eight is the idle task.
   localparam int TASK_ID_W = 4;
   localparam int PRIO_W    = 3;
   localparam int DELAY_W   = 32;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int OUT_TICK_W = 32;

   localparam logic [TASK_ID_W-1:0] IDLE_TASK = 4'd8;
   localparam logic [TASK_ID_W-1:0] NO_TASK   = 4'd15;

   // Input actions.
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_DELAY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Task status codes.
   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_WAITING = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_MAP = 2'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PICK,
      S_COMMIT
   } state_type;

   // Command to one cell, per cycle.
   typedef struct packed {
      logic clear;
      logic tick;
      logic delay;
      logic commit;
      logic from_tick;
      logic is_current;
      logic is_next;
   } cell_cmd_type;

   // Best candidate handed along the chain.
   typedef struct packed {
      logic [TASK_ID_W-1:0] prio;
      logic [TASK_ID_W-1:0] idx;
   } chain_type;

endpackage

// ===== rtl/core/pst_cell.sv =====
// One task cell of the scheduler chain: status and remaining delay of a task,
// and one step of the priority ripple. Depends on pst_pkg.
module pst_cell
   import pst_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic                 in_use,
   input  logic [PRIO_W-1:0]    prio,
   input  logic [DELAY_W-1:0]   delay,
   input  chain_type            chain_in,
   output chain_type            chain_out
);

   logic [1:0]         status_ff, status_in;
   logic [DELAY_W-1:0] remaining_ff, remaining_in;
   logic               eligible;

   // Status and countdown update.
   always_comb begin
      status_in    = status_ff;
      remaining_in = remaining_ff;
      if (cmd.clear) begin
         status_in    = ST_READY;
         remaining_in = '0;
      end else if (cmd.tick) begin
         if (in_use && status_ff == ST_WAITING) begin
            if (remaining_ff <= DELAY_W'(1)) begin
               remaining_in = '0;
               status_in    = ST_READY;
            end else begin
               remaining_in = remaining_ff - DELAY_W'(1);
            end
         end
      end else if (cmd.delay) begin
         if (in_use && cmd.is_current) begin
            status_in    = ST_WAITING;
            remaining_in = (delay == '0) ? DELAY_W'(1) : delay;
         end
      end else if (cmd.commit) begin
         if (cmd.from_tick && cmd.is_current && status_ff == ST_RUNNING) begin
            status_in = ST_READY;
         end
         if (cmd.is_next) begin
            status_in = ST_RUNNING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_READY;
         remaining_ff <= '0;
      end else begin
         status_ff    <= status_in;
         remaining_ff <= remaining_in;
      end
   end

   // This cell takes over the candidate only on a strictly better priority,
   // so the lowest index wins a tie.
   assign eligible = in_use && (status_ff == ST_READY || status_ff == ST_RUNNING) &&
                     ({1'b0, prio} < chain_in.prio);

   always_comb begin
      chain_out = chain_in;
      if (eligible) begin
         chain_out.prio = {1'b0, prio};
         chain_out.idx  = TASK_ID_W'(CELL_INDEX);
      end
   end

endmodule

// ===== rtl/core/priority_task_scheduler_with_delays_unit.sv =====
// Top level of the fixed-priority preemptive task scheduler with tick delays.
// Depends on pst_pkg and pst_cell.
//
// Usage:
//   The req_ channel carries events: tick, delay request by the running task,
//   or start and clear. Each accepted transaction yields exactly one rsp_
//   transaction carrying the running task (8 is the idle task), whether the
//   running task changed, and the low 32 bits of the tick counter.
//   The csr_ channel writes task_count (index 0) and priority_map (index 1);
//   it is always ready; the user must write it only while no event is in flight, the block itself does not enforce it.
// Operation:
//   An event passes through three steps: in the accept cycle every task cell
//   updates its status and countdown; in the pick state the best candidate
//   ripples through the chain of cells and is registered; in the commit state
//   the switch is committed and the result is loaded into the output register.
//   A new event is taken only back in idle, not before the last one is committed.
// Reset:
//   Synchronous reset makes every task ready with no delay, no task running,
//   the tick counter zero, task_count one and priority_map zero.
// Stall:
//   The result waits in the output register while the next event is taken
//   and processed; that event holds in its commit cycle until the register
//   is free.
module priority_task_scheduler_with_delays_unit
   import pst_pkg::*;
#(
   parameter int MAX_TASKS  = 8,
   parameter int TICK_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_action,
   input  logic [DELAY_W-1:0]     req_delay_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TASK_ID_W-1:0]   rsp_running_task,
   output logic                   rsp_switch_requested,
   output logic [OUT_TICK_W-1:0]  rsp_tick_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [3:0]            task_count_ff;
   logic [CSR_DATA_W-1:0] priority_map_ff;
   logic [1:0]            action_ff;
   logic [TASK_ID_W-1:0]  current_ff, current_in;
   logic [TASK_ID_W-1:0]  best_ff;
   logic [TICK_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  rsp_valid_ff;
   logic [TASK_ID_W-1:0]  rsp_task_ff, rsp_task_in;
   logic                  rsp_sw_ff, rsp_sw_in;
   logic [OUT_TICK_W-1:0] rsp_tick_in;
   logic [OUT_TICK_W-1:0] rsp_tick_ff;
   logic [OUT_TICK_W-1:0] elapsed_low;

   logic accept, commit_fire, slot_free, is_event, do_switch;

   chain_type    chain [MAX_TASKS+1];
   cell_cmd_type cmd [MAX_TASKS];

   assign accept      = req_valid && req_ready;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign commit_fire = (state_ff == S_COMMIT) && slot_free;
   assign is_event    = (action_ff == ACT_TICK) || (action_ff == ACT_DELAY);
   assign do_switch   = is_event && (best_ff != current_ff);

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff   <= 4'd1;
         priority_map_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TASK_COUNT:   task_count_ff   <= csr_wdata[3:0];
            CSR_PRIORITY_MAP: priority_map_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Controller next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_PICK;
         S_PICK:   state_in = S_COMMIT;
         S_COMMIT: if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Event capture and the chosen candidate.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
      end
      if (state_ff == S_PICK) begin
         best_ff <= chain[MAX_TASKS].idx;
      end
   end

   // Current task and tick counter.
   always_comb begin
      current_in = current_ff;
      elapsed_in = elapsed_ff;
      if (accept && req_action == ACT_CLEAR) begin
         current_in = NO_TASK;
         elapsed_in = '0;
      end else if (accept && req_action == ACT_TICK) begin
         elapsed_in = elapsed_ff + TICK_WIDTH'(1);
      end else if (commit_fire && do_switch) begin
         current_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= NO_TASK;
         elapsed_ff <= '0;
      end else begin
         current_ff <= current_in;
         elapsed_ff <= elapsed_in;
      end
   end

   generate
      if (TICK_WIDTH >= OUT_TICK_W) begin : g_tick_trunc
         assign elapsed_low = elapsed_ff[OUT_TICK_W-1:0];
      end else begin : g_tick_ext
         assign elapsed_low = {{(OUT_TICK_W-TICK_WIDTH){1'b0}}, elapsed_ff};
      end
   endgenerate

   // The chain of task cells.
   assign chain[0].prio = TASK_ID_W'(8);
   assign chain[0].idx  = IDLE_TASK;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      always_comb begin
         cmd[i].clear      = accept && (req_action == ACT_CLEAR);
         cmd[i].tick       = accept && (req_action == ACT_TICK);
         cmd[i].delay      = accept && (req_action == ACT_DELAY);
         cmd[i].commit     = commit_fire && do_switch;
         cmd[i].from_tick  = (action_ff == ACT_TICK);
         cmd[i].is_current = (current_ff == TASK_ID_W'(i));
         cmd[i].is_next    = (best_ff == TASK_ID_W'(i));
      end

      pst_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd[i]),
         .in_use    (TASK_ID_W'(i) < task_count_ff),
         .prio      (priority_map_ff[PRIO_W*i +: PRIO_W]),
         .delay     (req_delay_ticks),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   // Result payload.
   always_comb begin
      rsp_task_in = do_switch ? best_ff : current_ff;
      if (rsp_task_in > IDLE_TASK) begin
         rsp_task_in = IDLE_TASK;
      end
      rsp_sw_in   = do_switch;
      rsp_tick_in = elapsed_low;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_task_ff <= rsp_task_in;
         rsp_sw_ff   <= rsp_sw_in;
         rsp_tick_ff <= rsp_tick_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_running_task     = rsp_task_ff;
   assign rsp_switch_requested = rsp_sw_ff;
   assign rsp_tick_count       = rsp_tick_ff;

   // The current task is always a task in range, the idle task or none.
   a_current_range: assert property (@(posedge clock) disable iff (reset)
      (current_ff < TASK_ID_W'(MAX_TASKS)) || (current_ff == IDLE_TASK) ||
      (current_ff == NO_TASK))
      else $error("current task holds an impossible identifier");

   // An accepted transaction always moves on to the priority ripple.
   a_accept_pick: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PICK))
      else $error("accepted transaction did not enter the pick cycle");

   // A reported switch installs the candidate chosen by the chain.
   a_switch_install: assert property (@(posedge clock) disable iff (reset)
      (commit_fire && do_switch) |=> (current_ff == $past(best_ff)))
      else $error("switch did not install the chosen task");

   // A result is loaded only from the commit cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && (state_ff != S_COMMIT)) |=> !rsp_valid_ff)
      else $error("result appeared without a commit");

endmodule

// ===== verif/tb_priority_task_scheduler_with_delays_unit.sv =====
// Self-checking testbench for priority_task_scheduler_with_delays_unit: directed and random
// events under random back-pressure, checked against a cycle-free scheduler model.
// Depends on pst_pkg and the scheduler RTL.
module tb_priority_task_scheduler_with_delays_unit
   import pst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Action code that the block must ignore.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int TASK_SLOTS = 8;
   // Priority bound above every real priority.
   localparam int PRIO_NONE = 8;
   localparam int LONG_HOLD = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [TASK_ID_W-1:0]  task_id;
      logic                  switched;
      logic [OUT_TICK_W-1:0] ticks;
   } sched_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_action = ACT_TICK;
   logic [DELAY_W-1:0]     req_delay_ticks = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TASK_ID_W-1:0]   rsp_running_task;
   logic                   rsp_switch_requested;
   logic [OUT_TICK_W-1:0]  rsp_tick_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TASK_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Scheduler model state and configuration.
   logic [3:0]            cfg_task_count;
   logic [23:0]           cfg_prio_map;
   logic [1:0]            model_status [TASK_SLOTS];
   logic [31:0]           model_remaining [TASK_SLOTS];
   logic [TASK_ID_W-1:0]  model_current;
   logic [OUT_TICK_W-1:0] model_ticks;

   sched_result_type pending_results [$];

   int  mismatch_count = 0;
   int  events_sent = 0;
   int  results_checked = 0;
   int  settings_written = 0;
   bit  sender_eager = 1'b0;
   bit  hold_request = 1'b0;
   int  stall_left = 0;
   int  burst_left = 0;
   bit  burst_busy = 1'b0;

   priority_task_scheduler_with_delays_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_delay_ticks     (req_delay_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_running_task    (rsp_running_task),
      .rsp_switch_requested(rsp_switch_requested),
      .rsp_tick_count      (rsp_tick_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   // Return the model to the state after a start-and-clear event.
   function automatic void clear_schedule();
      for (int i = 0; i < TASK_SLOTS; i++) begin
         model_status[i]    = ST_READY;
         model_remaining[i] = '0;
      end
      model_current = NO_TASK;
      model_ticks   = '0;
   endfunction

   // Apply one event to the model and return the result it must produce.
   function automatic sched_result_type schedule_event(input logic [1:0] act,
                                                       input logic [31:0] dly);
      sched_result_type res;
      int               n;
      int               pick;
      int               best_prio;
      logic             switched;
      n = (cfg_task_count > TASK_SLOTS) ? TASK_SLOTS : int'(cfg_task_count);
      switched = 1'b0;
      if (act == ACT_CLEAR) begin
         clear_schedule();
      end else if (act == ACT_TICK || act == ACT_DELAY) begin
         if (act == ACT_TICK) begin
            // Count down every waiting task in use.
            model_ticks = model_ticks + 1'b1;
            for (int i = 0; i < n; i++) begin
               if (model_status[i] == ST_WAITING) begin
                  if (model_remaining[i] <= 1) begin
                     model_remaining[i] = '0;
                     model_status[i]    = ST_READY;
                  end else begin
                     model_remaining[i] = model_remaining[i] - 1;
                  end
               end
            end
         end else if (model_current < n) begin
            model_status[model_current]    = ST_WAITING;
            model_remaining[model_current] = (dly == 0) ? 32'd1 : dly;
         end
         // Lowest priority value wins, lowest index on a tie.
         pick      = IDLE_TASK;
         best_prio = PRIO_NONE;
         for (int i = 0; i < n; i++) begin
            if ((model_status[i] == ST_READY || model_status[i] == ST_RUNNING) &&
                cfg_prio_map[3*i +: 3] < best_prio) begin
               best_prio = cfg_prio_map[3*i +: 3];
               pick      = i;
            end
         end
         if (pick != model_current) begin
            switched = 1'b1;
            if (act == ACT_TICK && model_current < TASK_SLOTS &&
                model_status[model_current] == ST_RUNNING)
               model_status[model_current] = ST_READY;
            model_current = pick[TASK_ID_W-1:0];
            if (pick < TASK_SLOTS)
               model_status[pick] = ST_RUNNING;
         end
      end
      res.task_id  = (model_current <= IDLE_TASK) ? model_current : IDLE_TASK;
      res.switched = switched;
      res.ticks    = model_ticks;
      return res;
   endfunction

   // Sender gap: mostly none or short, now and then long.
   function automatic int request_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_eager || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one event and record its expected result once it is taken.
   task automatic send_event(input logic [1:0] act, input logic [31:0] dly);
      int gap;
      gap = request_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_delay_ticks <= dly;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(schedule_event(act, dly));
      events_sent++;
   endtask

   // Stop offering events and wait until every expected result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the block is drained first so that it is idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_TASK_COUNT)
         cfg_task_count = data[3:0];
      else if (idx == CSR_PRIORITY_MAP)
         cfg_prio_map = data;
      settings_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random event, weighted towards ticks and short delays.
   task automatic send_random_event();
      int          r;
      logic [1:0]  act;
      logic [31:0] dly;
      r   = $urandom_range(0, 99);
      dly = $urandom();
      if (r < 60) begin
         act = ACT_TICK;
      end else if (r < 95) begin
         act = ACT_DELAY;
         r   = $urandom_range(0, 99);
         if (r < 70)
            dly = $urandom_range(0, 12);
         else if (r < 90)
            dly = $urandom_range(13, 300);
      end else if (r < 98) begin
         act = ACT_CLEAR;
      end else begin
         act = ACT_UNUSED;
      end
      send_event(act, dly);
   endtask

   // Default configuration: the ignored code, tick, zero delay and the longest delay.
   task automatic test_reset_defaults();
      send_event(ACT_UNUSED, 32'h0);
      send_event(ACT_TICK, 32'hFFFF_FFFF);
      send_event(ACT_DELAY, 32'h0);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_DELAY, 32'hFFFF_FFFF);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_CLEAR, 32'hA5A5_A5A5);
      send_event(ACT_TICK, 32'h5A5A_5A5A);
   endtask

   // No tasks in use, oversized task count, priority ties and preemption.
   task automatic test_directed_cases();
      write_register(CSR_TASK_COUNT, 24'h0);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_DELAY, 32'd5);
      write_register(CSR_TASK_COUNT, 24'hFFFF_FF);
      write_register(CSR_PRIORITY_MAP, 24'hFF_FFFF);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_DELAY, 32'd2);
      send_event(ACT_DELAY, 32'd0);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_TICK, 32'h0);
      // Task seven alone at the top priority preempts on the next tick.
      write_register(CSR_PRIORITY_MAP, 24'h1F_FFFF);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_DELAY, 32'd3);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_TICK, 32'h0);
      send_event(ACT_TICK, 32'h0);
      // Shrinking the task count leaves the running task out of range.
      write_register(CSR_TASK_COUNT, 24'h2);
      send_event(ACT_DELAY, 32'd4);
      send_event(ACT_TICK, 32'h0);
      write_register(CSR_PRIORITY_MAP, 24'h0);
      send_event(ACT_DELAY, 32'h8000_0000);
      send_event(ACT_TICK, 32'h0);
   endtask

   // Random phases, each under a fresh configuration.
   task automatic test_random_phases();
      logic [3:0]  counts [8];
      logic [23:0] maps [8];
      counts = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd9, 4'd5, 4'd8};
      maps   = '{24'hFF_FFFF, 24'h00_0000, 24'hFA_C688, 24'h05_39D7,
                 24'h00_0000, 24'hFF_FFFF, 24'h00_0000, 24'h00_0000};
      maps[4] = 24'($urandom());
      maps[6] = 24'($urandom());
      maps[7] = 24'($urandom());
      counts[6] = 4'($urandom_range(0, 15));
      for (int p = 0; p < 8; p++) begin
         write_register(CSR_TASK_COUNT, {20'($urandom_range(0, 1048575)), counts[p]});
         write_register(CSR_PRIORITY_MAP, maps[p]);
         sender_eager = (p % 3 == 2);
         repeat (220) send_random_event();
         sender_eager = 1'b0;
      end
   endtask

   // Long receiver hold-off while events keep coming, then a full pause.
   task automatic test_backpressure();
      write_register(CSR_TASK_COUNT, 24'h8);
      write_register(CSR_PRIORITY_MAP, 24'h35_3A10);
      @(posedge clock);
      hold_request = 1'b1;
      sender_eager = 1'b1;
      repeat (24) send_random_event();
      sender_eager = 1'b0;
      drain_results();
      repeat (24) send_random_event();
   endtask

   // Receiver: bursts of steady acceptance and bursts of random stalls.
   always @(negedge clock) begin
      int r;
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(20, 80);
            burst_busy = ($urandom_range(0, 2) != 0);
         end
         burst_left--;
         r = $urandom_range(0, 99);
         if (!burst_busy || r < 55) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("Unexpected result: task %0d switch %0b ticks %0d",
                        rsp_running_task, rsp_switch_requested, rsp_tick_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_running_task !== want.task_id ||
                rsp_switch_requested !== want.switched ||
                rsp_tick_count !== want.ticks) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("Result %0d mismatch: want %0d/%0b/%0d, got %0d/%0b/%0d",
                           results_checked, want.task_id, want.switched, want.ticks,
                           rsp_running_task, rsp_switch_requested, rsp_tick_count);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      cfg_task_count = 4'd1;
      cfg_prio_map   = '0;
      clear_schedule();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_random_phases();
      test_backpressure();
      drain_results();
      $display("Covered %0d events with %0d results checked across %0d register writes,",
               events_sent, results_checked, settings_written);
      $display("including idle, oversized task counts, priority ties and a long output stall.");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_priority_task_scheduler_with_delays_unit OK");
      else
         $display("tb_priority_task_scheduler_with_delays_unit NOT OK");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("tb_priority_task_scheduler_with_delays_unit NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pst_pkg.sv
rtl/core/pst_cell.sv
rtl/core/priority_task_scheduler_with_delays_unit.sv
verif/tb_priority_task_scheduler_with_delays_unit.sv
